// ===== hw/rtl/sxbt_pkg.sv =====
`timescale 1ns / 1ps

package sxbt_pkg;

  // default trie geometry
  localparam int unsigned DefWidthBits = 21;
  localparam int unsigned DefMaxItems  = 1024;

  // fixed field widths
  localparam int unsigned ValueW = 21;
  localparam int unsigned PairW  = 11;
  localparam int unsigned TotalW = 20;

  // saturation limits of the result fields
  localparam logic [PairW-1:0]  PairMax  = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StInsLv,
    StSrchRd,
    StSrchLv,
    StFinish
  } state_e;

endpackage

// ===== hw/rtl/subarray_xor_below_threshold_counter_unit.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake               payload
// in       input      in_valid_i/in_stall_o   value_i, start_req_i
// out      output     out_valid_o/out_stall_i pair_count_o, running_total_o, overflow_o
// cfg      input      cfg_we_i                cfg_wdata_i (threshold)
//
// an accepted beat has its result registered after the insert walk, one level per cycle,
// a root read, then the search walk, which stops early once it leaves the trie, and once
// the output register is free; input reopens as the result is registered.
// a beat refused because the trie is full skips both walks and goes straight to the finish state.
// reset and start clear the trie through a root valid flag and the node fill count.
// input is taken only while idle; a result that cannot move out holds the sequencer.
module subarray_xor_below_threshold_counter_unit #(
  parameter int unsigned WidthBits = sxbt_pkg::DefWidthBits,
  parameter int unsigned MaxItems  = sxbt_pkg::DefMaxItems
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sxbt_pkg::ValueW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sxbt_pkg::ValueW-1:0]   value_i,
  input  logic                          start_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sxbt_pkg::PairW-1:0]    pair_count_o,
  output logic [sxbt_pkg::TotalW-1:0]   running_total_o,
  output logic                          overflow_o
);

  localparam int unsigned NodeCount = 1 + MaxItems * WidthBits;
  localparam int unsigned AddrW     = $clog2(NodeCount);
  localparam int unsigned HitsW     = $clog2(MaxItems + 1);
  localparam int unsigned LvlW      = (WidthBits > 1) ? $clog2(WidthBits) : 1;
  localparam int unsigned NodeW     = 2 * AddrW + 2 * HitsW;
  localparam int unsigned AccW      = sxbt_pkg::TotalW + 1;

  typedef struct packed {
    logic [AddrW-1:0] link1;
    logic [AddrW-1:0] link0;
    logic [HitsW-1:0] hits1;
    logic [HitsW-1:0] hits0;
  } node_t;

  sxbt_pkg::state_e state_q, state_d;

  logic [sxbt_pkg::ValueW-1:0] thr_q;
  logic [WidthBits-1:0]        prefix_q, prefix_d;
  logic [AddrW-1:0]            next_free_q, next_free_d;
  logic [HitsW-1:0]            items_q, items_d;
  logic [sxbt_pkg::TotalW-1:0] total_q, total_d;
  logic                        root_valid_q, root_valid_d;
  logic                        out_valid_q, out_valid_d;

  logic [LvlW-1:0]             lvl_q, lvl_d;
  logic [AddrW-1:0]            node_q, node_d;
  logic [WidthBits-1:0]        key_q, key_d;
  logic [WidthBits-1:0]        val_q, val_d;
  logic [HitsW-1:0]            sum_q, sum_d;
  logic                        zero_q, zero_d;
  logic                        ovf_q, ovf_d;
  logic [sxbt_pkg::PairW-1:0]  pair_q;
  logic [sxbt_pkg::TotalW-1:0] tot_out_q;
  logic                        ovf_out_q;

  logic                 in_accept;
  logic                 full_eff;
  logic                 out_load;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_raddr;
  logic [NodeW-1:0]     ram_rdata;
  node_t                node_rd, node_wr;
  logic [WidthBits-1:0] val_w, thr_w;
  logic                 key_bit, thr_bit;
  logic [AddrW-1:0]     ins_link, ins_next, alloc_id, srch_next;
  logic                 need_alloc, pool_full, ins_stop, ins_last, srch_last;
  logic [HitsW-1:0]     hit_b;
  logic [AccW-1:0]      sum_ext, tot_sum;
  logic [sxbt_pkg::PairW-1:0]  pair_sat;
  logic [sxbt_pkg::TotalW-1:0] tot_sat;

  // field views at trie width
  assign val_w = WidthBits'(value_i);
  assign thr_w = WidthBits'(thr_q);

  assign in_accept = in_valid_i && !in_stall_o;
  assign full_eff  = !start_req_i && (items_q == HitsW'(MaxItems));

  // current node, zero when fresh or before the root is first written
  assign node_rd = zero_q ? '0 : node_t'(ram_rdata);
  assign key_bit = key_q[lvl_q];
  assign thr_bit = thr_w[lvl_q];

  // insert step
  assign ins_link   = key_bit ? node_rd.link1 : node_rd.link0;
  assign need_alloc = (ins_link == '0);
  assign pool_full  = (next_free_q == AddrW'(NodeCount - 1));
  assign ins_stop   = need_alloc && pool_full;
  assign alloc_id   = next_free_q + AddrW'(1);
  assign ins_next   = need_alloc ? alloc_id : ins_link;
  assign ins_last   = ins_stop || (lvl_q == '0);

  always_comb begin
    node_wr = node_rd;
    if (key_bit) begin
      node_wr.link1 = ins_next;
      node_wr.hits1 = node_rd.hits1 + HitsW'(1);
    end else begin
      node_wr.link0 = ins_next;
      node_wr.hits0 = node_rd.hits0 + HitsW'(1);
    end
  end

  // search step
  assign hit_b     = key_bit ? node_rd.hits1 : node_rd.hits0;
  assign srch_next = (key_bit ^ thr_bit) ? node_rd.link1 : node_rd.link0;
  assign srch_last = (lvl_q == '0) || (srch_next == '0);

  // result saturation
  assign sum_ext  = AccW'(sum_q);
  assign tot_sum  = {1'b0, total_q} + sum_ext;
  assign pair_sat = (sum_ext > AccW'(sxbt_pkg::PairMax)) ? sxbt_pkg::PairMax
                                                          : sum_ext[sxbt_pkg::PairW-1:0];
  assign tot_sat  = (tot_sum > AccW'(sxbt_pkg::TotalMax)) ? sxbt_pkg::TotalMax
                                                           : tot_sum[sxbt_pkg::TotalW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sxbt_pkg::StIdle: begin
        if (in_accept) begin
          state_d = full_eff ? sxbt_pkg::StFinish : sxbt_pkg::StInsLv;
        end
      end
      sxbt_pkg::StInsLv: begin
        if (ins_last) begin
          state_d = sxbt_pkg::StSrchRd;
        end
      end
      sxbt_pkg::StSrchRd: begin
        state_d = sxbt_pkg::StSrchLv;
      end
      sxbt_pkg::StSrchLv: begin
        if (srch_last) begin
          state_d = sxbt_pkg::StFinish;
        end
      end
      sxbt_pkg::StFinish: begin
        if (out_load) begin
          state_d = sxbt_pkg::StIdle;
        end
      end
      default: state_d = sxbt_pkg::StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = '0;
    unique case (state_q)
      sxbt_pkg::StIdle: begin
        in_stall_o = 1'b0;
      end
      sxbt_pkg::StInsLv: begin
        ram_we    = !ins_stop;
        ram_raddr = ins_next;
      end
      sxbt_pkg::StSrchRd: begin
        ram_raddr = '0;
      end
      sxbt_pkg::StSrchLv: begin
        ram_raddr = srch_next;
      end
      sxbt_pkg::StFinish: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // datapath
  always_comb begin
    prefix_d     = prefix_q;
    next_free_d  = next_free_q;
    items_d      = items_q;
    total_d      = total_q;
    root_valid_d = root_valid_q;
    lvl_d        = lvl_q;
    node_d       = node_q;
    key_d        = key_q;
    val_d        = val_q;
    sum_d        = sum_q;
    zero_d       = zero_q;
    ovf_d        = ovf_q;
    unique case (state_q)
      sxbt_pkg::StIdle: begin
        if (in_accept) begin
          if (start_req_i) begin
            prefix_d     = '0;
            next_free_d  = '0;
            items_d      = '0;
            total_d      = '0;
            root_valid_d = 1'b0;
          end
          val_d  = val_w;
          key_d  = start_req_i ? '0 : prefix_q;
          lvl_d  = LvlW'(WidthBits - 1);
          node_d = '0;
          zero_d = start_req_i || !root_valid_q;
          sum_d  = '0;
          ovf_d  = full_eff;
        end
      end
      sxbt_pkg::StInsLv: begin
        if (need_alloc && !pool_full) begin
          next_free_d = alloc_id;
        end
        if (!ins_stop && (node_q == '0)) begin
          root_valid_d = 1'b1;
        end
        node_d = ins_next;
        zero_d = need_alloc;
        lvl_d  = lvl_q - LvlW'(1);
        if (ins_last) begin
          prefix_d = prefix_q ^ val_q;
          key_d    = prefix_q ^ val_q;
          items_d  = items_q + HitsW'(1);
        end
      end
      sxbt_pkg::StSrchRd: begin
        node_d = '0;
        lvl_d  = LvlW'(WidthBits - 1);
        zero_d = !root_valid_q;
      end
      sxbt_pkg::StSrchLv: begin
        if (thr_bit) begin
          sum_d = sum_q + hit_b;
        end
        node_d = srch_next;
        zero_d = 1'b0;
        lvl_d  = lvl_q - LvlW'(1);
      end
      sxbt_pkg::StFinish: begin
        if (out_load) begin
          total_d = tot_sat;
        end
      end
      default: begin
        ovf_d = ovf_q;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sxbt_pkg::StIdle;
      thr_q        <= '0;
      prefix_q     <= '0;
      next_free_q  <= '0;
      items_q      <= '0;
      total_q      <= '0;
      root_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      prefix_q     <= prefix_d;
      next_free_q  <= next_free_d;
      items_q      <= items_d;
      total_q      <= total_d;
      root_valid_q <= root_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    node_q <= node_d;
    key_q  <= key_d;
    val_q  <= val_d;
    sum_q  <= sum_d;
    zero_q <= zero_d;
    ovf_q  <= ovf_d;
    if (out_load) begin
      pair_q    <= pair_sat;
      tot_out_q <= tot_sat;
      ovf_out_q <= ovf_q;
    end
  end

  // trie node memory
  sxbt_ram #(
    .Width(NodeW),
    .Depth(NodeCount)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(node_q),
    .wdata_i(NodeW'(node_wr)),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign pair_count_o    = pair_q;
  assign running_total_o = tot_out_q;
  assign overflow_o      = ovf_out_q;

`ifndef NO_ASSERTIONS
  a_items_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= HitsW'(MaxItems))
    else $error("inserted prefix count beyond limit");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q < AddrW'(NodeCount))
    else $error("node allocation beyond pool");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sxbt_pkg::StFinish) |-> (sum_q <= items_q))
    else $error("search count exceeds inserted prefixes");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (pair_count_o == '0))
    else $error("refused beat reports matches");

  a_finish_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sxbt_pkg::StFinish) && !out_valid_q) |=> (state_q == sxbt_pkg::StIdle))
    else $error("result not moved to free output register");
`endif

endmodule

// ===== hw/rtl/sxbt_ram.sv =====
`timescale 1ns / 1ps

module sxbt_ram #(
  parameter int unsigned Width = 52,
  parameter int unsigned Depth = 21505
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb_subarray_xor_below_threshold_counter_unit.sv =====
`timescale 1ns / 1ps

module tb_subarray_xor_below_threshold_counter_unit;
  import sxbt_pkg::*;

  localparam int unsigned MaxItems   = DefMaxItems;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned HoldAtBeat = 40;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              start;
  } element_t;

  typedef struct packed {
    logic [PairW-1:0]  pair;
    logic [TotalW-1:0] total;
    logic              ovf;
  } result_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [ValueW-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [ValueW-1:0] in_value  = '0;
  logic              in_start  = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PairW-1:0]  pair_count;
  logic [TotalW-1:0] running_total;
  logic              overflow;

  // beats waiting to be sent and results waiting to be seen
  element_t pending_elems [$];
  result_t  expected_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned rx_beats      = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;

  // mirror of the sequence state: earlier prefixes of the current sequence
  logic [ValueW-1:0] seq_prefixes [$];
  logic [ValueW-1:0] seq_prefix      = '0;
  int unsigned       seq_items       = 0;
  logic [TotalW-1:0] seq_total       = '0;
  logic [ValueW-1:0] model_threshold = '0;

  subarray_xor_below_threshold_counter_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .value_i        (in_value),
    .start_req_i    (in_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pair_count_o   (pair_count),
    .running_total_o(running_total),
    .overflow_o     (overflow)
  );

  always #2 clk = ~clk;

  // count earlier prefixes whose xor with the new prefix is under the threshold
  function automatic result_t score_element(element_t e);
    result_t         r;
    int unsigned     hit_total;
    longint unsigned sum;
    r = '0;
    if (e.start) begin
      seq_prefixes.delete();
      seq_prefix = '0;
      seq_items  = 0;
      seq_total  = '0;
    end
    // trie full: refused, nothing changes
    if (seq_items >= MaxItems) begin
      r.total = seq_total;
      r.ovf   = 1'b1;
      return r;
    end
    seq_prefixes = {seq_prefixes, seq_prefix};
    seq_items++;
    seq_prefix = seq_prefix ^ e.value;
    hit_total = 0;
    for (int i = 0; i < seq_prefixes.size(); i++) begin
      if ((seq_prefixes[i] ^ seq_prefix) < model_threshold) hit_total++;
    end
    sum = longint'(seq_total) + hit_total;
    seq_total = (sum > TotalMax) ? TotalMax : sum[TotalW-1:0];
    r.pair  = (hit_total > PairMax) ? PairMax : hit_total[PairW-1:0];
    r.total = seq_total;
    return r;
  endfunction

  function automatic logic [ValueW-1:0] pick_threshold();
    logic [ValueW-1:0] t;
    case ($urandom_range(3))
      0: t = ValueW'($urandom_range(64));
      1: t = ValueW'(1) << $urandom_range(ValueW - 1);
      2: t = ValueW'($urandom);
      default: t = '1;
    endcase
    return t;
  endfunction

  // mix of clustered and spread values so counts are not always zero
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(3))
      0: v = ValueW'($urandom_range(15));
      1: v = ValueW'($urandom_range(3)) << (ValueW - 2);
      default: v = ValueW'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_element(input logic [ValueW-1:0] v, input logic s);
    element_t e;
    e.value = v;
    e.start = s;
    pending_elems = {pending_elems, e};
  endtask

  task automatic random_chunk(input int unsigned count, input bit lead_start,
                              input int unsigned start_pct);
    bit s;
    for (int i = 0; i < count; i++) begin
      s = (i == 0 && lead_start) || ($urandom_range(99) < start_pct);
      queue_element(pick_value(), s);
    end
  endtask

  // sender holds back until every result is back
  task automatic wait_idle();
    while (pending_elems.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [ValueW-1:0] t);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    model_threshold = t;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // input driver: offer the head of the pending queue, hold it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results = {expected_results, score_element(pending_elems.pop_front())};
      if (!(in_valid && in_stall)) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_value <= pending_elems[0].value;
          in_start <= pending_elems[0].start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_beats++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && rx_beats == HoldAtBeat) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, expected none, actual pair %0d total %0d ovf %0d",
                 $time, pair_count, running_total, overflow);
      end else begin
        want = expected_results.pop_front();
        check_field("pair_count", want.pair, pair_count);
        check_field("running_total", want.total, running_total);
        check_field("overflow", want.ovf, overflow);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    recv_idle_pct = 70;

    // zero threshold: nothing ever matches
    set_threshold('0);
    queue_element(21'h000000, 1'b1);
    queue_element(21'h1FFFFF, 1'b0);
    queue_element(21'h155555, 1'b0);
    queue_element(21'h0AAAAA, 1'b0);
    queue_element(21'h000000, 1'b0);
    wait_idle();

    // full threshold: all but an all-ones xor match, restart mid sequence
    set_threshold('1);
    queue_element(21'h1FFFFF, 1'b1);
    queue_element(21'h1FFFFF, 1'b0);
    queue_element(21'h000000, 1'b0);
    queue_element(21'h000001, 1'b0);
    queue_element(21'h100000, 1'b0);
    queue_element(21'h000000, 1'b1);
    queue_element(21'h000000, 1'b0);
    wait_idle();

    // threshold one: only repeated prefixes match
    set_threshold(21'h000001);
    queue_element(21'h000000, 1'b1);
    queue_element(21'h000000, 1'b0);
    queue_element(21'h000000, 1'b0);
    queue_element(21'h000005, 1'b0);
    queue_element(21'h000005, 1'b0);
    wait_idle();

    // msb threshold: split on the top bit
    set_threshold(21'h100000);
    queue_element(21'h0FFFFF, 1'b1);
    queue_element(21'h100000, 1'b0);
    queue_element(21'h1FFFFF, 1'b0);
    queue_element(21'h0ABCDE, 1'b0);
    queue_element(21'h012345, 1'b0);
    wait_idle();

    // random sequences, sender mostly busy, receiver mostly stalled
    for (int k = 0; k < 3; k++) begin
      set_threshold(pick_threshold());
      random_chunk(50, 1'b1, 4);
      wait_idle();
    end

    // roles swapped
    send_idle_pct = 70;
    recv_idle_pct = 30;
    for (int k = 0; k < 3; k++) begin
      set_threshold(pick_threshold());
      random_chunk(50, 1'b1, 4);
      wait_idle();
    end

    // no idling: one sequence past the trie capacity, threshold moved on the way
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 4; k++) begin
      set_threshold(k == 0 ? '1 : (k == 2 ? '0 : pick_threshold()));
      random_chunk(260, k == 0, 0);
      wait_idle();
    end

    // restart while the trie is full, then short sequences
    set_threshold(pick_threshold());
    queue_element(pick_value(), 1'b1);
    random_chunk(12, 1'b0, 20);
    wait_idle();

    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
